@@ rtl/image_resampler_nn_bilinear_assert.svh @@
// Assertion macros for the RTL, used by irs_fifo; clock aclk, synchronous active-low reset aresetn
`ifndef IMAGE_RESAMPLER_NN_BILINEAR_ASSERT_SVH
`define IMAGE_RESAMPLER_NN_BILINEAR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define IRS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/irs_pkg.sv @@
package irs_pkg;

    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int POS_W    = 12;
    localparam int PIX_W    = 8;
    localparam int SIZE_W   = 10;
    localparam int SCALE_W  = 24;
    localparam int EFF_W    = 13;   // holds any size up to 4096
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int FIFO_DEPTH = 4;

    localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT = SIZE_W'(512);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_SCALE_X    = 3'd2,
        REG_SCALE_Y    = 3'd3,
        REG_MODE       = 3'd4
    } cfg_reg_t;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    // number of index bits for a dimension, at least two so a half index exists
    function automatic int idx_bits(input int n);
        int b;
        b = $clog2(n);
        return (b < 2) ? 2 : b;
    endfunction

endpackage

@@ rtl/irs_ram.sv @@
module irs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

@@ rtl/irs_fifo.sv @@
module irs_fifo import irs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);
    localparam int PTR_W = (DEPTH < 2) ? 1 : $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

`include "image_resampler_nn_bilinear_assert.svh"
    `IRS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "queue count overflow")
    `IRS_ASSERT_SAME(a_no_pop_empty, pop, !empty, "back end popped an empty queue")
    `IRS_ASSERT_SAME(a_no_push_full, push, !full, "front end pushed into a full queue")
    `IRS_ASSERT_NEXT(a_cnt_up, do_push && !do_pop, cnt_reg == $past(cnt_reg) + 1'b1,
        "queue count did not grow on push")
endmodule

@@ rtl/irs_front.sv @@
module irs_front import irs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int CW = idx_bits(MAX_WIDTH),
    parameter int RW = idx_bits(MAX_HEIGHT),
    parameter int EW = 1 + 2 * CW + 2 * RW + 2 * (FRAC_BITS + 1) + PIX_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_cmd,
    input  logic [POS_W-1:0]    in_pos_x,
    input  logic [POS_W-1:0]    in_pos_y,
    input  logic [PIX_W-1:0]    in_pix,
    input  logic [SIZE_W-1:0]   src_width,
    input  logic [SIZE_W-1:0]   src_height,
    input  logic [SCALE_W-1:0]  scale_x,
    input  logic [SCALE_W-1:0]  scale_y,
    input  logic                mode,
    output logic                push,
    output logic [EW-1:0]       push_data,
    input  logic                full
);
    localparam int FB = FRAC_BITS + 1;
    localparam int PW = POS_W + SCALE_W + 3;
    localparam int MW = POS_W + SCALE_W;
    localparam logic signed [PW-1:0] HALF_P = PW'(1) << FRAC_BITS;

    logic adv;
    logic [EFF_W-1:0] w_lim, h_lim;

    logic               f1_valid_reg, f2_valid_reg;
    logic               f1_cmd_reg, f2_cmd_reg;
    logic [POS_W-1:0]   f1_px_reg, f1_py_reg, f2_px_reg, f2_py_reg;
    logic [PIX_W-1:0]   f1_pix_reg, f2_pix_reg;
    logic [MW-1:0]      f1_mx_reg, f1_my_reg;
    logic signed [PW-1:0] f2_xp_reg, f2_yp_reg, f2_xp_next, f2_yp_next;

    logic signed [PW-1:0] x0, y0, xn, yn;
    logic [CW-1:0] xa, xb;
    logic [RW-1:0] ya, yb;
    logic [FB-1:0] fx, fy;
    logic in_range;

    // clamp a signed index to 0..lim
    function automatic logic [EFF_W-1:0] clamp_idx(input logic signed [PW-1:0] v,
                                                   input logic [EFF_W-1:0] lim);
        logic [EFF_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed({{(PW-EFF_W){1'b0}}, lim})) begin
            r = lim;
        end else begin
            r = v[EFF_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [EFF_W-1:0] size_lim(input logic [SIZE_W-1:0] sz, input int mx);
        logic [EFF_W-1:0] r;
        if (sz == '0) begin
            r = '0;
        end else if (EFF_W'(sz) > EFF_W'(mx)) begin
            r = EFF_W'(mx - 1);
        end else begin
            r = EFF_W'(sz) - 1'b1;
        end
        return r;
    endfunction

    assign w_lim = size_lim(src_width, MAX_WIDTH);
    assign h_lim = size_lim(src_height, MAX_HEIGHT);

    assign adv      = !full;
    assign in_ready = adv;
    assign in_range = ({1'b0, in_pos_x} <= w_lim) && ({1'b0, in_pos_y} <= h_lim);

    // 2*pos*scale + scale - 2^FRAC_BITS, FB fraction bits
    assign f2_xp_next = $signed({2'b00, f1_mx_reg, 1'b0})
                      + $signed({{(PW-SCALE_W){1'b0}}, scale_x}) - HALF_P;
    assign f2_yp_next = $signed({2'b00, f1_my_reg, 1'b0})
                      + $signed({{(PW-SCALE_W){1'b0}}, scale_y}) - HALF_P;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= in_valid && (in_cmd == CMD_READ || in_range);
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_cmd_reg <= in_cmd;
            f1_px_reg  <= in_pos_x;
            f1_py_reg  <= in_pos_y;
            f1_pix_reg <= in_pix;
            f1_mx_reg  <= MW'(in_pos_x) * MW'(scale_x);
            f1_my_reg  <= MW'(in_pos_y) * MW'(scale_y);
            f2_cmd_reg <= f1_cmd_reg;
            f2_px_reg  <= f1_px_reg;
            f2_py_reg  <= f1_py_reg;
            f2_pix_reg <= f1_pix_reg;
            f2_xp_reg  <= f2_xp_next;
            f2_yp_reg  <= f2_yp_next;
        end
    end

    always_comb begin
        x0 = f2_xp_reg >>> FB;
        y0 = f2_yp_reg >>> FB;
        xn = (f2_xp_reg < 0) ? '0 : ((f2_xp_reg + HALF_P) >>> FB);
        yn = (f2_yp_reg < 0) ? '0 : ((f2_yp_reg + HALF_P) >>> FB);
        if (f2_cmd_reg == CMD_WRITE) begin
            xa = f2_px_reg[CW-1:0];
            xb = f2_px_reg[CW-1:0];
            ya = f2_py_reg[RW-1:0];
            yb = f2_py_reg[RW-1:0];
            fx = '0;
            fy = '0;
        end else if (mode == MODE_NEAREST) begin
            // one pixel read with zero weights on the far neighbors
            xa = CW'(clamp_idx(xn, w_lim));
            xb = xa;
            ya = RW'(clamp_idx(yn, h_lim));
            yb = ya;
            fx = '0;
            fy = '0;
        end else begin
            xa = CW'(clamp_idx(x0, w_lim));
            xb = CW'(clamp_idx(x0 + PW'(1), w_lim));
            ya = RW'(clamp_idx(y0, h_lim));
            yb = RW'(clamp_idx(y0 + PW'(1), h_lim));
            fx = f2_xp_reg[FB-1:0];
            fy = f2_yp_reg[FB-1:0];
        end
    end

    assign push      = f2_valid_reg && adv;
    assign push_data = {f2_cmd_reg, xa, xb, ya, yb, fx, fy, f2_pix_reg};
endmodule

@@ rtl/irs_back.sv @@
module irs_back import irs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    parameter int CW = idx_bits(MAX_WIDTH),
    parameter int RW = idx_bits(MAX_HEIGHT),
    parameter int EW = 1 + 2 * CW + 2 * RW + 2 * (FRAC_BITS + 1) + PIX_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [EW-1:0]     head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PIX_W-1:0]  out_pix
);
    localparam int FB = FRAC_BITS + 1;
    localparam int AW = (CW - 1) + (RW - 1);
    localparam int TW = PIX_W + FB + 1;
    localparam int SW = TW + FB + 1;
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    logic          h_cmd;
    logic [CW-1:0] h_xa, h_xb;
    logic [RW-1:0] h_ya, h_yb;
    logic [FB-1:0] h_fx, h_fy;
    logic [PIX_W-1:0] h_pix;
    logic adv;
    logic [PIX_W-1:0] bank_q [4];

    logic          b1_valid_reg, b2_valid_reg, b3_valid_reg, out_valid_reg;
    logic [FB-1:0] b1_fx_reg, b1_fy_reg, b2_fy_reg;
    logic          b1_xa0_reg, b1_xb0_reg, b1_ya0_reg, b1_yb0_reg;
    logic [TW-1:0] b2_top_reg, b2_bot_reg, top_next, bot_next;
    logic [SW-1:0] b3_sum_reg, sum_next, rnd;
    logic [PIX_W-1:0] out_pix_reg;
    logic [PIX_W:0] r9;
    logic [PIX_W-1:0] paa, pba, pab, pbb;

    assign {h_cmd, h_xa, h_xb, h_ya, h_yb, h_fx, h_fy, h_pix} = head;
    assign adv = !out_valid_reg || out_ready;
    assign pop = adv && !empty;

    // four banks by row and column parity; an unclamped neighbor pair spans both parities
    for (genvar g = 0; g < 4; g++) begin : g_bank
        localparam logic BR = (g >= 2);
        localparam logic BC = ((g % 2) == 1);
        logic [CW-1:0] col_sel;
        logic [RW-1:0] row_sel;
        logic [AW-1:0] addr;
        logic          wen;

        assign col_sel = (h_xa[0] == BC) ? h_xa : h_xb;
        assign row_sel = (h_ya[0] == BR) ? h_ya : h_yb;
        assign addr    = {row_sel[RW-1:1], col_sel[CW-1:1]};
        assign wen     = pop && (h_cmd == CMD_WRITE) && (h_xa[0] == BC) && (h_ya[0] == BR);

        irs_ram #(.WIDTH(PIX_W), .DEPTH(1 << AW)) u_ram (
            .aclk  (aclk),
            .we    (wen),
            .waddr (addr),
            .wdata (h_pix),
            .re    (pop),
            .raddr (addr),
            .rdata (bank_q[g])
        );
    end

    always_comb begin
        // far neighbors with zero weight may sit on pixels never loaded
        paa = bank_q[{b1_ya0_reg, b1_xa0_reg}];
        pba = (b1_fx_reg == '0) ? '0 : bank_q[{b1_ya0_reg, b1_xb0_reg}];
        pab = (b1_fy_reg == '0) ? '0 : bank_q[{b1_yb0_reg, b1_xa0_reg}];
        pbb = (b1_fx_reg == '0 || b1_fy_reg == '0) ? '0
            : bank_q[{b1_yb0_reg, b1_xb0_reg}];
        top_next = TW'(TW'(paa) * TW'(ONE - (FB + 1)'(b1_fx_reg)))
                 + TW'(TW'(pba) * TW'(b1_fx_reg));
        bot_next = TW'(TW'(pab) * TW'(ONE - (FB + 1)'(b1_fx_reg)))
                 + TW'(TW'(pbb) * TW'(b1_fx_reg));
        sum_next = SW'(SW'(b2_top_reg) * SW'(ONE - (FB + 1)'(b2_fy_reg)))
                 + SW'(SW'(b2_bot_reg) * SW'(b2_fy_reg));
        rnd = b3_sum_reg + (SW'(1) << (2 * FB - 1));
        r9  = rnd[2 * FB +: PIX_W + 1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            b1_valid_reg  <= pop && (h_cmd == CMD_READ);
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            out_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_fx_reg  <= h_fx;
            b1_fy_reg  <= h_fy;
            b1_xa0_reg <= h_xa[0];
            b1_xb0_reg <= h_xb[0];
            b1_ya0_reg <= h_ya[0];
            b1_yb0_reg <= h_yb[0];
            b2_top_reg <= top_next;
            b2_bot_reg <= bot_next;
            b2_fy_reg  <= b1_fy_reg;
            b3_sum_reg <= sum_next;
            out_pix_reg <= r9[PIX_W] ? {PIX_W{1'b1}} : r9[PIX_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
endmodule

@@ rtl/image_resampler_nn_bilinear.sv @@
// Throughput: one word per cycle, writes and requests alike, while the queue is not full
// and m_tready does not stall the blend path; the four neighbors come from four frame-store
// banks split by row and column parity, one read each. Write words give no result. A 4-entry
// queue separates mapping from fetch/blend.
// Reset (aresetn low, synchronous) clears control and configuration; frame store is not cleared.
module image_resampler_nn_bilinear import irs_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // pos_x[11:0], pos_y[23:12], pixel_in[31:24]
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // pixel_out[7:0]
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);
    localparam int CW = idx_bits(MAX_WIDTH);
    localparam int RW = idx_bits(MAX_HEIGHT);
    localparam int EW = 1 + 2 * CW + 2 * RW + 2 * (FRAC_BITS + 1) + PIX_W;

    logic [SIZE_W-1:0]  src_width_reg, src_height_reg;
    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg;
    logic               mode_reg;

    logic          push, full, pop, empty;
    logic [EW-1:0] push_data, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= RST_SRC_WIDTH;
            src_height_reg <= RST_SRC_HEIGHT;
            scale_x_reg    <= SCALE_W'(1) << FRAC_BITS;
            scale_y_reg    <= SCALE_W'(1) << FRAC_BITS;
            mode_reg       <= MODE_NEAREST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH:  src_width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SCALE_X:    scale_x_reg    <= cfg_wdata[SCALE_W-1:0];
                REG_SCALE_Y:    scale_y_reg    <= cfg_wdata[SCALE_W-1:0];
                REG_MODE:       mode_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    irs_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS),
        .CW(CW), .RW(RW), .EW(EW)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (s_tuser),
        .in_pos_x   (s_tdata[11:0]),
        .in_pos_y   (s_tdata[23:12]),
        .in_pix     (s_tdata[31:24]),
        .src_width  (src_width_reg),
        .src_height (src_height_reg),
        .scale_x    (scale_x_reg),
        .scale_y    (scale_y_reg),
        .mode       (mode_reg),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    irs_fifo #(.WIDTH(EW), .DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    irs_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .FRAC_BITS(FRAC_BITS),
        .CW(CW), .RW(RW), .EW(EW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (m_tdata)
    );
endmodule

@@ verif/tb_image_resampler_nn_bilinear.sv @@
`timescale 1ns / 1ps

module tb_image_resampler_nn_bilinear;
    import irs_pkg::*;

    localparam int MAXW = 512;
    localparam int MAXH = 512;
    localparam int FRAC = 16;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic              cmd;
        logic [11:0]       x;
        logic [11:0]       y;
        logic [7:0]        pix;
        bit                typed;
        logic [7:0]        want;
        cfg_reg_t          idx;
        logic [23:0]       val;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    image_resampler_nn_bilinear uut (.*);

    always #2 aclk = ~aclk;

    // predictor state
    logic [7:0]  plane [0:MAXW*MAXH-1];
    logic [9:0]  width_reg, height_reg;
    logic [23:0] sx_reg, sy_reg;
    logic        mode_reg;

    logic [7:0] pixel_q[$];
    int  errors = 0;
    int  results_seen = 0;
    bit  quiet = 0;
    bit  held = 0;

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic longint eff(input logic [9:0] r, input longint lim);
        if (r < 1) return 1;
        if (r > lim) return lim;
        return r;
    endfunction

    function automatic longint clampn(input longint v, input longint n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    function automatic logic [7:0] resample(input logic [11:0] dx, input logic [11:0] dy);
        longint w, h, xp, yp, x0, y0, fx, fy, xa, xb, ya, yb, one, top, bot, sum, r;
        w = eff(width_reg, MAXW);
        h = eff(height_reg, MAXH);
        one = longint'(1) << (FRAC + 1);
        xp = 2 * longint'(dx) * longint'(sx_reg) + longint'(sx_reg) - (longint'(1) << FRAC);
        yp = 2 * longint'(dy) * longint'(sy_reg) + longint'(sy_reg) - (longint'(1) << FRAC);
        if (mode_reg == MODE_NEAREST) begin
            xa = (xp < 0) ? 0 : clampn((xp + (longint'(1) << FRAC)) >>> (FRAC + 1), w);
            ya = (yp < 0) ? 0 : clampn((yp + (longint'(1) << FRAC)) >>> (FRAC + 1), h);
            return plane[ya*MAXW + xa];
        end
        x0 = xp >>> (FRAC + 1);
        y0 = yp >>> (FRAC + 1);
        fx = xp - x0 * one;
        fy = yp - y0 * one;
        xa = clampn(x0, w); xb = clampn(x0 + 1, w);
        ya = clampn(y0, h); yb = clampn(y0 + 1, h);
        top = plane[ya*MAXW+xa] * (one - fx) + plane[ya*MAXW+xb] * fx;
        bot = plane[yb*MAXW+xa] * (one - fx) + plane[yb*MAXW+xb] * fx;
        sum = top * (one - fy) + bot * fy;
        r = (sum + (longint'(1) << (2*FRAC + 1))) >>> (2*FRAC + 2);
        if (r > 255) r = 255;
        return r[7:0];
    endfunction

    // drive one word and wait for it to be taken; updates the predictor on acceptance
    task automatic send_word(input logic cmd, input logic [11:0] x, input logic [11:0] y,
                             input logic [7:0] pix, input int gap);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {pix, y, x};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_WRITE) begin
            if (x < eff(width_reg, MAXW) && y < eff(height_reg, MAXH))
                plane[y*MAXW + x] = pix;
        end else begin
            pixel_q.push_back(resample(x, y));
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);   // writes still in flight
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_SRC_WIDTH:  width_reg  = val[9:0];
            REG_SRC_HEIGHT: height_reg = val[9:0];
            REG_SCALE_X:    sx_reg     = val;
            REG_SCALE_Y:    sy_reg     = val;
            REG_MODE:       mode_reg   = val[0];
            default: ;
        endcase
    endtask

    function automatic int rand_gap();
        if (quiet || $urandom_range(0, 3) != 0) return 0;
        return $urandom_range(1, 9);
    endfunction

    function automatic stim_row_t wr(input logic [11:0] x, input logic [11:0] y,
                                     input logic [7:0] p);
        stim_row_t r;
        r = '{ROW_WORD, CMD_WRITE, x, y, p, 0, 8'h00, REG_MODE, 24'h0};
        return r;
    endfunction

    function automatic stim_row_t rd(input logic [11:0] x, input logic [11:0] y,
                                     input logic [7:0] want);
        stim_row_t r;
        r = '{ROW_WORD, CMD_READ, x, y, 8'h00, 1, want, REG_MODE, 24'h0};
        return r;
    endfunction

    function automatic stim_row_t cf(input cfg_reg_t idx, input logic [23:0] val);
        stim_row_t r;
        r = '{ROW_CFG, CMD_WRITE, 12'h0, 12'h0, 8'h00, 0, 8'h00, idx, val};
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pixel_q.size() == 0)
                report($sformatf("unexpected pixel_out %02h", m_tdata));
            else begin
                if (m_tdata !== pixel_q[0])
                    report($sformatf("pixel_out %02h, want %02h", m_tdata, pixel_q[0]));
                void'(pixel_q.pop_front());
            end
        end
    end

    // result side: random back-pressure, one long hold-off, none at the end
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 30) begin
                held = 1;
                m_tready = 1'b0;
                n = 0;
                while (n < 300) begin
                    @(negedge aclk);
                    n++;
                end
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    initial begin
        #2_000_000;
        $display("image_resampler_nn_bilinear test failed");
        $finish;
    end

    initial begin
        stim_row_t rows[$];
        int sent, w, h, nreq;
        logic [11:0] x, y;

        width_reg = 10'd512; height_reg = 10'd512;
        sx_reg = 24'h010000; sy_reg = 24'h010000; mode_reg = MODE_NEAREST;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        rows = '{
            wr(0, 0, 8'hA5), wr(511, 511, 8'h3C),
            wr(12'hFFF, 12'hFFF, 8'hFF), wr(512, 0, 8'h11),    // outside: dropped
            rd(0, 0, 8'hA5), rd(511, 511, 8'h3C), rd(12'hFFF, 12'hFFF, 8'h3C),
            cf(REG_SRC_WIDTH, 24'd0), cf(REG_SRC_HEIGHT, 24'd1023),
            cf(REG_SCALE_X, 24'd0), cf(REG_SCALE_Y, 24'd0),
            cf(REG_MODE, 24'(MODE_BILINEAR)),
            rd(12'hFFF, 0, 8'hA5), rd(17, 300, 8'hA5),
            wr(0, 511, 8'h80),
            cf(REG_SCALE_X, 24'hFFFFFF), cf(REG_SCALE_Y, 24'hFFFFFF),
            rd(12'hFFF, 12'hFFF, 8'h80),
            cf(REG_MODE, 24'(MODE_NEAREST)), rd(12'hFFF, 12'hFFF, 8'h80)
        };
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                send_word(rows[i].cmd, rows[i].x, rows[i].y, rows[i].pix, rand_gap());
                if (rows[i].typed && pixel_q[$] !== rows[i].want)
                    report($sformatf("row %0d predicts %02h, table says %02h",
                                     i, pixel_q[$], rows[i].want));
            end
        end

        sent = 0;
        while (sent < 600) begin
            drain();
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            write_reg(REG_SRC_WIDTH, 24'(w));
            write_reg(REG_SRC_HEIGHT, 24'(h));
            case ($urandom_range(0, 5))
                0: write_reg(REG_SCALE_X, 24'd0);
                1: write_reg(REG_SCALE_X, 24'hFFFFFF);
                2: write_reg(REG_SCALE_X, 24'($urandom_range(0, 24'hFFFFFF)));
                default: write_reg(REG_SCALE_X, 24'($urandom_range(24'h004000, 24'h040000)));
            endcase
            case ($urandom_range(0, 5))
                0: write_reg(REG_SCALE_Y, 24'd0);
                1: write_reg(REG_SCALE_Y, 24'hFFFFFF);
                2: write_reg(REG_SCALE_Y, 24'($urandom_range(0, 24'hFFFFFF)));
                default: write_reg(REG_SCALE_Y, 24'($urandom_range(24'h004000, 24'h040000)));
            endcase
            write_reg(REG_MODE, 24'($urandom_range(0, 1)));
            if (sent > 480) quiet = 1;

            // load the whole used plane so every neighbor is defined
            for (int r = 0; r < h; r++)
                for (int c = 0; c < w; c++) begin
                    send_word(CMD_WRITE, 12'(c), 12'(r), 8'($urandom_range(0, 255)),
                              rand_gap());
                    sent++;
                end
            nreq = $urandom_range(10, 40);
            for (int k = 0; k < nreq; k++) begin
                case ($urandom_range(0, 9))
                    0: begin   // write outside the plane
                        x = 12'($urandom_range(w, 4095));
                        y = 12'($urandom_range(0, 4095));
                        send_word(CMD_WRITE, x, y, 8'($urandom_range(0, 255)), rand_gap());
                    end
                    1: send_word(CMD_WRITE, 12'($urandom_range(0, w-1)),
                                 12'($urandom_range(0, h-1)),
                                 8'($urandom_range(0, 255)), rand_gap());
                    2: send_word(CMD_READ, 12'($urandom_range(0, 4095)),
                                 12'($urandom_range(0, 4095)),
                                 8'($urandom_range(0, 255)), rand_gap());
                    default:
                        send_word(CMD_READ, 12'($urandom_range(0, 2*w+2)),
                                  12'($urandom_range(0, 2*h+2)),
                                  8'($urandom_range(0, 255)), rand_gap());
                endcase
                sent++;
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("image_resampler_nn_bilinear test passed");
        else
            $display("image_resampler_nn_bilinear test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/irs_pkg.sv
rtl/irs_ram.sv
rtl/irs_fifo.sv
rtl/irs_front.sv
rtl/irs_back.sv
rtl/image_resampler_nn_bilinear.sv
verif/tb_image_resampler_nn_bilinear.sv
